// ===== hw/rtl/local_max_marker_3x3_macros.svh =====
// Assertion helpers shared by the checker.
// Both expect clk and arst_n in the scope where they are used.
`ifndef LOCAL_MAX_MARKER_3X3_MACROS_SVH
`define LOCAL_MAX_MARKER_3X3_MACROS_SVH

// Same-cycle implication.
`define LMM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmm: same-cycle check failed");

// Next-cycle implication.
`define LMM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmm: next-cycle check failed");

`endif

// ===== hw/rtl/lmm_pkg.sv =====
`timescale 1ns / 1ps

package lmm_pkg;

	localparam int MAX_COLS      = 62;
	localparam int PIXEL_BITS    = 16;
	localparam int MARK_BITS     = PIXEL_BITS + 1;
	localparam int ROW_BITS      = 12;
	localparam int COL_BITS      = 6;
	localparam int ROWS_MAX      = 4096;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;
	localparam int NUM_BANKS     = 3;
	localparam int BANK_BITS     = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_ROWS = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COLS = CFG_IDX_BITS'(1);

	localparam logic [BANK_BITS-1:0] BANK0 = BANK_BITS'(0);
	localparam logic [BANK_BITS-1:0] BANK1 = BANK_BITS'(1);
	localparam logic [BANK_BITS-1:0] BANK2 = BANK_BITS'(2);

	typedef logic signed [PIXEL_BITS-1:0] pixel_t;
	typedef logic signed [MARK_BITS-1:0]  mark_t;
	typedef logic [COL_BITS-1:0]          col_t;
	typedef logic [BANK_BITS-1:0]         bank_t;
	typedef pixel_t [NUM_BANKS-1:0]       bank_data_t;

	// One column step into the window: a real pixel, or a drain step over
	// the last row (has_below low, nothing written).
	typedef struct packed {
		logic   valid;
		col_t   col;
		bank_t  bank;
		logic   has_above;
		logic   has_above2;
		logic   has_below;
		logic   row_end;
		logic   hold_last;
		pixel_t pixel;
	} issue_t;

endpackage

// ===== hw/rtl/lmm_ram.sv =====
`timescale 1ns / 1ps

module lmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 62
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/lmm_seq.sv =====
`timescale 1ns / 1ps

module lmm_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	input  lmm_pkg::pixel_t                  pixel_value,
	output logic                             pix_stall,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lmm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [lmm_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                             issue_ok,
	output lmm_pkg::issue_t                  issue
);
	import lmm_pkg::*;

	logic [ROW_BITS-1:0] rows_m1_q;
	col_t                cols_m1_q;
	logic [ROW_BITS-1:0] row_q;
	col_t                col_q;
	bank_t               bank_q;
	logic                drain_q;
	col_t                dcol_q;
	bank_t               dbank_q;

	logic                row_end;
	logic                frame_last;
	logic                pix_fire;
	logic                drain_fire;
	logic [ROW_BITS-1:0] rows_m1_new;
	col_t                cols_m1_new;
	col_t                cols_raw;

	function automatic bank_t next_bank(input bank_t b);
		bank_t n;
		unique case (b)
			BANK0:   n = BANK1;
			BANK1:   n = BANK2;
			default: n = BANK0;
		endcase
		return n;
	endfunction

	assign row_end    = (col_q == cols_m1_q);
	assign frame_last = row_end && (row_q == rows_m1_q);

	assign cfg_ready  = 1'b1;
	assign pix_stall  = drain_q || !issue_ok || cfg_valid;
	assign pix_fire   = pix_valid && !pix_stall;
	assign drain_fire = drain_q && issue_ok;

	// clamp register values to the legal frame size
	assign cols_raw = cfg_data[COL_BITS-1:0];
	always_comb begin
		if (cfg_data == '0) begin
			rows_m1_new = '0;
		end else if (cfg_data > CFG_DATA_BITS'(ROWS_MAX)) begin
			rows_m1_new = ROW_BITS'(ROWS_MAX - 1);
		end else begin
			rows_m1_new = ROW_BITS'(cfg_data - CFG_DATA_BITS'(1));
		end
		if (cols_raw == '0) begin
			cols_m1_new = '0;
		end else if (cols_raw > COL_BITS'(MAX_COLS)) begin
			cols_m1_new = COL_BITS'(MAX_COLS - 1);
		end else begin
			cols_m1_new = cols_raw - COL_BITS'(1);
		end
	end

	always_comb begin
		issue.pixel = pixel_value;
		if (drain_q) begin
			// last row revisited as the row above a row that does not exist
			issue.valid      = drain_fire;
			issue.col        = dcol_q;
			issue.bank       = dbank_q;
			issue.has_above  = 1'b1;
			issue.has_above2 = (rows_m1_q != '0);
			issue.has_below  = 1'b0;
			issue.row_end    = (dcol_q == cols_m1_q);
			// the whole drain belongs to the last pixel's run
			issue.hold_last  = (dcol_q != cols_m1_q);
		end else begin
			issue.valid      = pix_fire;
			issue.col        = col_q;
			issue.bank       = bank_q;
			issue.has_above  = (row_q != '0);
			issue.has_above2 = (row_q > ROW_BITS'(1));
			issue.has_below  = 1'b1;
			issue.row_end    = row_end;
			issue.hold_last  = frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m1_q <= '0;
			cols_m1_q <= '0;
			row_q     <= '0;
			col_q     <= '0;
			bank_q    <= BANK0;
			drain_q   <= 1'b0;
			dcol_q    <= '0;
			dbank_q   <= BANK0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FRAME_ROWS: begin
						rows_m1_q <= rows_m1_new;
						row_q     <= '0;
						col_q     <= '0;
						bank_q    <= BANK0;
					end
					REG_FRAME_COLS: begin
						cols_m1_q <= cols_m1_new;
						row_q     <= '0;
						col_q     <= '0;
						bank_q    <= BANK0;
					end
					default: begin
					end
				endcase
			end else if (pix_fire) begin
				if (row_end) begin
					col_q <= '0;
					if (row_q == rows_m1_q) begin
						row_q   <= '0;
						bank_q  <= BANK0;
						drain_q <= 1'b1;
						dcol_q  <= '0;
						dbank_q <= next_bank(bank_q);
					end else begin
						row_q  <= row_q + ROW_BITS'(1);
						bank_q <= next_bank(bank_q);
					end
				end else begin
					col_q <= col_q + COL_BITS'(1);
				end
			end
			if (drain_fire) begin
				if (dcol_q == cols_m1_q) begin
					drain_q <= 1'b0;
				end else begin
					dcol_q <= dcol_q + COL_BITS'(1);
				end
			end
		end
	end

endmodule

// ===== hw/rtl/lmm_eval.sv =====
`timescale 1ns / 1ps

module lmm_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  lmm_pkg::issue_t     issue,
	input  lmm_pkg::bank_data_t rd_data,
	output logic                issue_ok,
	output logic                res_valid,
	input  logic                res_stall,
	output lmm_pkg::mark_t      marked_value,
	output logic                is_peak,
	output logic                last_of_run
);
	import lmm_pkg::*;

	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} column_t;

	typedef struct packed {
		mark_t marked;
		logic  peak;
		logic  last;
	} result_t;

	typedef pixel_t [7:0] nbr_t;

	logic    valid_s1;
	issue_t  item_s1;
	column_t win1_q;
	column_t win2_q;
	result_t e0_q;
	result_t e1_q;
	logic [1:0] cnt_q;

	column_t    cur;
	logic       c1;
	logic       c2;
	logic       up2;
	logic       dn;
	nbr_t       nbr_a;
	nbr_t       nbr_b;
	logic [7:0] ex_a;
	logic [7:0] ex_b;
	logic       peak_a;
	logic       peak_b;
	result_t    res_a;
	result_t    res_b;
	logic       emit_a;
	logic       emit_b;
	logic [1:0] n_res;
	logic       pop;
	logic [1:0] cnt_ap;
	logic       consume;
	logic [1:0] push_n;
	result_t    r0;
	result_t    base0;
	result_t    e0_n;
	result_t    e1_n;

	function automatic bank_t prev1(input bank_t b);
		bank_t p;
		unique case (b)
			BANK0:   p = BANK2;
			BANK1:   p = BANK0;
			default: p = BANK1;
		endcase
		return p;
	endfunction

	function automatic bank_t prev2(input bank_t b);
		bank_t p;
		unique case (b)
			BANK0:   p = BANK1;
			BANK1:   p = BANK2;
			default: p = BANK0;
		endcase
		return p;
	endfunction

	function automatic logic peak_check(input pixel_t center, input nbr_t nbr,
	                                    input logic [7:0] ex);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 8; k++) begin
			if (ex[k] && ($signed(center) <= $signed(nbr[k]))) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic mark_t mark_of(input pixel_t center, input logic peak);
		mark_t ext;
		ext = {center[PIXEL_BITS-1], center};
		return peak ? -ext : ext;
	endfunction

	// newest column: two stored rows plus the pixel itself
	always_comb begin
		cur.top = rd_data[prev2(item_s1.bank)];
		cur.mid = rd_data[prev1(item_s1.bank)];
		cur.bot = item_s1.pixel;
	end

	assign c1  = (item_s1.col != '0);
	assign c2  = (item_s1.col > COL_BITS'(1));
	assign up2 = item_s1.has_above2;
	assign dn  = item_s1.has_below;

	// A: centered one column back. B: row-end pixel centered on the new column.
	assign nbr_a = {win2_q.top, win2_q.mid, win2_q.bot, win1_q.top, win1_q.bot,
	                cur.top, cur.mid, cur.bot};
	assign ex_a  = {c2 && up2, c2, c2 && dn, up2, dn, up2, 1'b1, dn};
	assign nbr_b = {win1_q.top, win1_q.mid, win1_q.bot, cur.top, cur.bot,
	                {(3*PIXEL_BITS){1'b0}}};
	assign ex_b  = {c1 && up2, c1, c1 && dn, up2, dn, 3'b000};

	assign peak_a = peak_check(win1_q.mid, nbr_a, ex_a);
	assign peak_b = peak_check(cur.mid, nbr_b, ex_b);

	assign emit_a = valid_s1 && item_s1.has_above && c1;
	assign emit_b = valid_s1 && item_s1.has_above && item_s1.row_end;
	assign n_res  = {1'b0, emit_a} + {1'b0, emit_b};

	always_comb begin
		res_a.marked = mark_of(win1_q.mid, peak_a);
		res_a.peak   = peak_a;
		res_a.last   = !emit_b && !item_s1.hold_last;
		res_b.marked = mark_of(cur.mid, peak_b);
		res_b.peak   = peak_b;
		res_b.last   = !item_s1.hold_last;
	end

	assign r0 = emit_a ? res_a : res_b;

	// two-entry result queue; e0 drives the outputs
	assign pop      = (cnt_q != 2'd0) && !res_stall;
	assign cnt_ap   = cnt_q - {1'b0, pop};
	assign consume  = valid_s1 && (({1'b0, cnt_ap} + {1'b0, n_res}) <= 3'd2);
	assign issue_ok = !valid_s1 || consume;
	assign push_n   = consume ? n_res : 2'd0;
	assign base0    = pop ? e1_q : e0_q;

	always_comb begin
		case (cnt_ap)
			2'd0: begin
				e0_n = r0;
				e1_n = res_b;
			end
			2'd1: begin
				e0_n = base0;
				e1_n = r0;
			end
			default: begin
				e0_n = base0;
				e1_n = e1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (issue.valid) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			cnt_q <= cnt_ap + push_n;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.valid) begin
			item_s1 <= issue;
		end
		if (consume) begin
			win2_q <= win1_q;
			win1_q <= cur;
		end
		e0_q <= e0_n;
		e1_q <= e1_n;
	end

	assign res_valid    = (cnt_q != 2'd0);
	assign marked_value = e0_q.marked;
	assign is_peak      = e0_q.peak;
	assign last_of_run  = e0_q.last;

endmodule

// ===== hw/rtl/local_max_marker_3x3.sv =====
`timescale 1ns / 1ps

// Streaming 3x3 strict local-maximum marker. Pixels of a frame_rows x
// frame_cols raster come in row-major order, one per clock when not stalled;
// each pixel that is strictly above every in-frame neighbor comes out negated
// with is_peak set, others come out unchanged. Results trail the input by one
// row and one column; each row end releases up to two results, carried by a
// two-entry output queue so the pixel rate stays at one per clock unless
// res_stall fills the queue. The last pixel of a frame releases the whole
// last row as well: the pixel input is then held off while the drain
// sequencer rereads the last two lines from the three line banks, one column
// per clock unless the queue is full. last_of_run marks the final result that
// a pixel releases. Register writes restart the frame position; they hold off
// pixel requests in the cycle they are taken and belong between frames.

module local_max_marker_3x3 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  lmm_pkg::pixel_t                  pixel_value,
	output logic                             res_valid,
	input  logic                             res_stall,
	output lmm_pkg::mark_t                   marked_value,
	output logic                             is_peak,
	output logic                             last_of_run,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lmm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [lmm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import lmm_pkg::*;

	issue_t               issue;
	logic                 issue_ok;
	bank_data_t           rd_data;
	logic [NUM_BANKS-1:0] bank_we;

	lmm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pixel_value (pixel_value),
		.pix_stall   (pix_stall),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.issue_ok    (issue_ok),
		.issue       (issue)
	);

	// one bank per row mod 3; every step reads all banks at its column
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		assign bank_we[b] = issue.valid && issue.has_below &&
		                    (issue.bank == BANK_BITS'(b));

		lmm_ram #(
			.WIDTH (PIXEL_BITS),
			.DEPTH (MAX_COLS)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (issue.col),
			.wdata (issue.pixel),
			.re    (issue.valid),
			.raddr (issue.col),
			.rdata (rd_data[b])
		);
	end

	lmm_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.issue        (issue),
		.rd_data      (rd_data),
		.issue_ok     (issue_ok),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.marked_value (marked_value),
		.is_peak      (is_peak),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== hw/rtl/lmm_checker.sv =====
`timescale 1ns / 1ps
`include "local_max_marker_3x3_macros.svh"

module lmm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pix_stall,
	input logic           res_valid,
	input logic           res_stall,
	input lmm_pkg::mark_t marked_value,
	input logic           is_peak,
	input logic           last_of_run,
	input logic           cfg_valid,
	input logic           cfg_ready
);
	import lmm_pkg::*;

	// a stalled result holds
	`LMM_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(marked_value) && $stable(is_peak) && $stable(last_of_run))

	// register writes are never held off
	`LMM_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

	// a register write keeps pixel requests out in the same cycle
	`LMM_ASSERT_IMP(a_cfg_blocks_pix, cfg_valid, pix_stall)

	// only a negated most-negative peak leaves the pixel range
	`LMM_ASSERT_IMP(a_mark_range, res_valid && (marked_value[MARK_BITS-1] != marked_value[PIXEL_BITS-1]), is_peak && (marked_value[PIXEL_BITS-2:0] == '0))

endmodule

bind local_max_marker_3x3 lmm_checker u_lmm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pix_stall    (pix_stall),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.marked_value (marked_value),
	.is_peak      (is_peak),
	.last_of_run  (last_of_run),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lmm_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = CFG_IDX_BITS'(2);
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_TARGET   = 230;
	localparam int CALM_FROM     = 195;
	localparam int DIR_STEPS     = 21;

	typedef struct packed {
		mark_t value;
		logic  peak;
		logic  last;
	} mark_rec_t;

	typedef enum logic {STEP_CFG, STEP_PIX} step_e;

	typedef struct {
		step_e                    kind;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] data;
		pixel_t                   pix;
		bit                       typed;
		mark_t                    want_value;
		logic                     want_peak;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pixel_t pixel_value;
	logic res_valid;
	logic res_stall;
	mark_t marked_value;
	logic is_peak;
	logic last_of_run;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// predictor state
	pixel_t raster_lines [3][MAX_COLS];
	int row_pos;
	int col_pos;
	logic [12:0] rows_reg;
	logic [5:0] cols_reg;
	mark_rec_t pending_marks[$];
	mark_rec_t released_marks[$];

	int mismatch_count;
	int pixels_sent;
	bit calm;
	step_t plan [DIR_STEPS];
	mark_rec_t want_rec;

	local_max_marker_3x3 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pixel_value  (pixel_value),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.marked_value (marked_value),
		.is_peak      (is_peak),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rows_in_use();
		if (rows_reg == 0) return 1;
		if (rows_reg > ROWS_MAX) return ROWS_MAX;
		return int'(rows_reg);
	endfunction

	function automatic int cols_in_use();
		if (cols_reg == 0) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return int'(cols_reg);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			REG_FRAME_ROWS: rows_reg = val;
			REG_FRAME_COLS: cols_reg = val[5:0];
			default: return;
		endcase
		row_pos = 0;
		col_pos = 0;
	endfunction

	function automatic void add_released(mark_rec_t rec);
		released_marks = {released_marks, rec};
	endfunction

	function automatic void add_pending(mark_rec_t rec);
		pending_marks = {pending_marks, rec};
	endfunction

	// Marks the stored pixel at (i, j) against the neighbors inside the frame.
	function automatic mark_rec_t mark_at(int i, int j, int rows, int cols);
		pixel_t v;
		mark_t wide;
		logic peak;
		int ni;
		int nj;
		mark_rec_t rec;
		v = raster_lines[i % 3][j];
		peak = 1'b1;
		for (int di = -1; di <= 1; di++)
			for (int dj = -1; dj <= 1; dj++) begin
				ni = i + di;
				nj = j + dj;
				if ((di != 0 || dj != 0) && ni >= 0 && ni < rows && nj >= 0 && nj < cols)
					if (v <= raster_lines[ni % 3][nj]) peak = 1'b0;
			end
		wide = mark_t'(v);
		rec.value = peak ? -wide : wide;
		rec.peak = peak;
		rec.last = 1'b0;
		return rec;
	endfunction

	function automatic void predict_marks(pixel_t v);
		int rows;
		int cols;
		int r;
		int c;
		rows = rows_in_use();
		cols = cols_in_use();
		released_marks.delete();
		if (row_pos >= rows || col_pos >= cols) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		raster_lines[r % 3][c] = v;
		if (r >= 1) begin
			if (c >= 1) add_released(mark_at(r - 1, c - 1, rows, cols));
			if (c == cols - 1) add_released(mark_at(r - 1, c, rows, cols));
		end
		// last pixel of the frame drains the whole bottom row
		if (r == rows - 1 && c == cols - 1)
			for (int j = 0; j < cols; j++) add_released(mark_at(r, j, rows, cols));
		if (released_marks.size() != 0)
			released_marks[released_marks.size() - 1].last = 1'b1;
		c++;
		if (c >= cols) begin
			c = 0;
			r++;
			if (r >= rows) r = 0;
		end
		row_pos = r;
		col_pos = c;
	endfunction

	function automatic pixel_t random_pixel();
		// narrow values make ties between neighbors common
		if ($urandom_range(0, 2) == 0) return pixel_t'(int'($urandom_range(0, 3)) - 2);
		return pixel_t'($urandom);
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("%0t ns: %s", $time, what);
	endtask

	task automatic wait_drained(bit settle);
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_marks.size() != 0) @(posedge clk);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(pixel_t v, bit typed, mark_rec_t typed_rec);
		if (!calm && $urandom_range(0, 3) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_value <= v;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		predict_marks(v);
		if (typed) add_pending(typed_rec);
		else foreach (released_marks[k]) add_pending(released_marks[k]);
		pixels_sent++;
		if (pixels_sent >= CALM_FROM) calm = 1'b1;
	endtask

	task automatic run_frame(logic [CFG_DATA_BITS-1:0] rows_val,
			logic [CFG_DATA_BITS-1:0] cols_val, int count, int hold_at);
		wait_drained(1'b1);
		write_reg(REG_FRAME_ROWS, rows_val);
		write_reg(REG_FRAME_COLS, cols_val);
		for (int k = 0; k < count; k++) begin
			if (k == hold_at) wait_drained(1'b0);
			send_pixel(random_pixel(), 1'b0, '0);
		end
	endtask

	// result stall: random bursts, none once the run turns calm
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (pending_marks.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", marked_value));
			end else begin
				want_rec = pending_marks.pop_front();
				if (marked_value !== want_rec.value)
					report_mismatch($sformatf("marked_value %0d, expected %0d",
						marked_value, want_rec.value));
				if (is_peak !== want_rec.peak)
					report_mismatch($sformatf("is_peak %b, expected %b",
						is_peak, want_rec.peak));
				if (last_of_run !== want_rec.last)
					report_mismatch($sformatf("last_of_run %b, expected %b",
						last_of_run, want_rec.last));
			end
		end
	end

	initial begin
		mark_rec_t fixed_rec;
		int r_sel;
		int c_sel;
		int n_sel;
		int hold_sel;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pixel_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_ROWS;
		cfg_data = '0;
		rows_reg = 13'd1;
		cols_reg = 6'd1;
		row_pos = 0;
		col_pos = 0;
		mismatch_count = 0;
		pixels_sent = 0;
		calm = 1'b0;
		foreach (raster_lines[i, j]) raster_lines[i][j] = '0;

		// 1x1 frames after reset: no neighbors, so every pixel is a peak
		plan = '{
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd32767, 1'b1, -17'sd32767, 1'b1},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sh8000, 1'b1, 17'sd32768, 1'b1},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd0, 1'b1, 17'sd0, 1'b1},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, -16'sd1, 1'b1, 17'sd1, 1'b1},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sh5555, 1'b1, -17'sd21845, 1'b1},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'shAAAA, 1'b1, 17'sd21846, 1'b1},
			'{STEP_CFG, REG_FRAME_ROWS, 13'd3, 16'sd0, 1'b0, 17'sd0, 1'b0},
			'{STEP_CFG, REG_FRAME_COLS, 13'd3, 16'sd0, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sh8000, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd32767, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sh8000, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd4, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd4, 1'b0, 17'sd0, 1'b0},
			// unmapped index mid-frame: must not restart the frame
			'{STEP_CFG, REG_UNMAPPED, 13'h1FFF, 16'sd0, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd4, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd3, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, -16'sd1, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd3, 1'b0, 17'sd0, 1'b0},
			// zero sizes act as one; cols keeps only its low six bits
			'{STEP_CFG, REG_FRAME_ROWS, 13'd0, 16'sd0, 1'b0, 17'sd0, 1'b0},
			'{STEP_CFG, REG_FRAME_COLS, 13'h1FC0, 16'sd0, 1'b0, 17'sd0, 1'b0},
			'{STEP_PIX, REG_FRAME_ROWS, 13'd0, 16'sd100, 1'b1, -17'sd100, 1'b1}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == STEP_CFG) begin
				wait_drained(1'b1);
				write_reg(plan[k].idx, plan[k].data);
			end else begin
				fixed_rec.value = plan[k].want_value;
				fixed_rec.peak = plan[k].want_peak;
				fixed_rec.last = 1'b1;
				send_pixel(plan[k].pix, plan[k].typed, fixed_rec);
			end
		end

		// widest line (63 saturates to the store depth): drain of 62 results
		run_frame(13'd2, 13'd63, 124, -1);
		// row count saturates at 4096; partial frames, one with a full drain pause
		run_frame(13'h1FFF, 13'd1, 10, 5);
		run_frame(13'h1000, 13'd2, 8, -1);

		while (pixels_sent < ITEM_TARGET) begin
			r_sel = $urandom_range(1, 5);
			c_sel = $urandom_range(1, 8);
			n_sel = r_sel * c_sel * $urandom_range(1, 2);
			if (n_sel > 1 && $urandom_range(0, 4) == 0) n_sel = $urandom_range(1, n_sel - 1);
			if (n_sel > ITEM_TARGET - pixels_sent) n_sel = ITEM_TARGET - pixels_sent;
			hold_sel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_sel - 1) : -1;
			run_frame(CFG_DATA_BITS'(r_sel), CFG_DATA_BITS'(c_sel), n_sel, hold_sel);
		end

		wait_drained(1'b0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_marks.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
